/* sv/dpap_pkg.sv */
// ----------------------------------------------------------------------------
// dpap_pkg
// Shared widths, quadrant bases and transaction types for the diamond
// pseudo-angle pair block.
// ----------------------------------------------------------------------------
package dpap_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int ANGLE_W    = FRAC_BITS + 2;

	localparam logic [1:0] QUAD_BASE_0 = 2'd0;
	localparam logic [1:0] QUAD_BASE_1 = 2'd1;
	localparam logic [1:0] QUAD_BASE_2 = 2'd2;
	localparam logic [1:0] QUAD_BASE_3 = 2'd3;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] first_x;
		logic signed [COORD_BITS-1:0] first_y;
		logic signed [COORD_BITS-1:0] second_x;
		logic signed [COORD_BITS-1:0] second_y;
	} dpap_req_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] first_angle;
		logic [ANGLE_W-1:0] second_angle;
		logic [ANGLE_W-1:0] angle_between;
	} dpap_rsp_t;

endpackage

/* sv/dpap_lane.sv */
// ----------------------------------------------------------------------------
// dpap_lane
// One vector's pseudo-angle: quadrant selection, then a restoring divider
// pipelined one quotient bit per stage.
// ----------------------------------------------------------------------------
module dpap_lane import dpap_pkg::*; #(
	parameter int COORD_W = COORD_BITS,
	parameter int FRAC_W  = FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [COORD_W-1:0] x,
	input  logic signed [COORD_W-1:0] y,
	output logic [FRAC_W+1:0]         angle
);

	localparam int DW = COORD_W + 1;
	localparam int EW = COORD_W + 2;

	logic signed [EW-1:0] xe, ye;
	logic signed [EW-1:0] sum_xy, dif_yx, neg_sum, dif_xy, neg_x, neg_y;
	logic [DW-1:0]        num_c, den_c;
	logic [1:0]           base_c;

	logic [DW-1:0]     rem_s  [FRAC_W+1];
	logic [DW-1:0]     den_s  [FRAC_W+1];
	logic [FRAC_W-1:0] quo_s  [FRAC_W+1];
	logic [1:0]        base_s [FRAC_W+1];

	assign xe      = EW'(x);
	assign ye      = EW'(y);
	assign sum_xy  = xe + ye;
	assign dif_yx  = ye - xe;
	assign neg_sum = -xe - ye;
	assign dif_xy  = xe - ye;
	assign neg_x   = -xe;
	assign neg_y   = -ye;

	always_comb begin
		num_c  = '0;
		den_c  = DW'(1);
		base_c = QUAD_BASE_0;
		if (y > 0) begin
			if (x > 0) begin
				base_c = QUAD_BASE_0;
				num_c  = ye[DW-1:0];
				den_c  = sum_xy[DW-1:0];
			end else begin
				base_c = QUAD_BASE_1;
				num_c  = neg_x[DW-1:0];
				den_c  = dif_yx[DW-1:0];
			end
		end else if (y < 0) begin
			if (x < 0) begin
				base_c = QUAD_BASE_2;
				num_c  = neg_y[DW-1:0];
				den_c  = neg_sum[DW-1:0];
			end else begin
				base_c = QUAD_BASE_3;
				num_c  = xe[DW-1:0];
				den_c  = dif_xy[DW-1:0];
			end
		end else begin
			// zero y: empty quotient, base only
			base_c = (x < 0) ? QUAD_BASE_2 : QUAD_BASE_0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num_c;
			den_s[0]  <= den_c;
			quo_s[0]  <= '0;
			base_s[0] <= base_c;
		end
	end

	for (genvar k = 1; k <= FRAC_W; k++) begin : g_div
		logic [DW:0] trial;
		logic [DW:0] shifted;

		assign shifted = {rem_s[k-1], 1'b0};
		assign trial   = shifted - {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[DW]) begin
					rem_s[k] <= trial[DW-1:0];
				end else begin
					rem_s[k] <= shifted[DW-1:0];
				end
				quo_s[k]  <= {quo_s[k-1][FRAC_W-2:0], ~trial[DW]};
				den_s[k]  <= den_s[k-1];
				base_s[k] <= base_s[k-1];
			end
		end
	end

	assign angle = {base_s[FRAC_W], quo_s[FRAC_W]};

endmodule

/* sv/dpap_merge.sv */
// ----------------------------------------------------------------------------
// dpap_merge
// Combine both lane angles, form the wrapped difference and hold the
// result transaction.
// ----------------------------------------------------------------------------
module dpap_merge import dpap_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [ANGLE_W-1:0] first_angle,
	input  logic [ANGLE_W-1:0] second_angle,
	output dpap_rsp_t          rsp_q
);

	logic [ANGLE_W-1:0] between;

	// wrap modulo four falls out of the fixed width
	assign between = second_angle - first_angle;

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.first_angle   <= first_angle;
			rsp_q.second_angle  <= second_angle;
			rsp_q.angle_between <= between;
		end
	end

endmodule

/* sv/diamond_pseudo_angle_pair_top.sv */
// ----------------------------------------------------------------------------
// diamond_pseudo_angle_pair_top
// Diamond pseudo-angles of two vectors and their wrapped difference.
// ----------------------------------------------------------------------------
// Takes one vector pair per clock cycle, unless stalled, and returns one
// result transaction per pair, in order. Each vector has its own lane: a
// quadrant-select register and then a restoring divider with one stage per
// quotient bit, so the divider depth sets the latency. A final register
// merges both lanes and forms the difference. The whole pipeline holds while
// a waiting result is stalled; otherwise it takes a new pair every cycle.
module diamond_pseudo_angle_pair_top import dpap_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  dpap_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output dpap_rsp_t rsp
);

	logic               en;
	logic [FRAC_BITS:0] vld_s;
	logic               rsp_valid_q;
	logic [ANGLE_W-1:0] first_angle, second_angle;

	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[FRAC_BITS-1:0], req_valid};
			rsp_valid_q <= vld_s[FRAC_BITS];
		end
	end

	dpap_lane #(
		.COORD_W (COORD_BITS),
		.FRAC_W  (FRAC_BITS)
	) u_lane_first (
		.clk   (clk),
		.en    (en),
		.x     (req.first_x),
		.y     (req.first_y),
		.angle (first_angle)
	);

	dpap_lane #(
		.COORD_W (COORD_BITS),
		.FRAC_W  (FRAC_BITS)
	) u_lane_second (
		.clk   (clk),
		.en    (en),
		.x     (req.second_x),
		.y     (req.second_y),
		.angle (second_angle)
	);

	dpap_merge u_merge (
		.clk          (clk),
		.en           (en),
		.first_angle  (first_angle),
		.second_angle (second_angle),
		.rsp_q        (rsp)
	);

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> vld_s[0])
		else $error("accepted transaction missing from first stage");

	a_rsp_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(vld_s[FRAC_BITS]))
		else $error("result valid without a transaction in the last stage");

	a_between: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.angle_between ==
			ANGLE_W'(rsp.second_angle - rsp.first_angle)))
		else $error("angle difference inconsistent with lane angles");

endmodule
